### hw/rtl/hvsr_pkg.sv
// Harmonic voice renderer: shared types, constants and per-timbre microcode.
// Used by hvsr_ctrl, hvsr_dp and the top level; no dependencies.
package hvsr_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ONE_Q           = 131072;
  localparam int CORR_Q          = 29491;
  localparam int TREM_BASE       = 107479;
  localparam int DIV_STEPS       = 18;

  // phase fed to the sine unit
  typedef enum logic [2:0] {
    SRC_PH      = 3'd0,
    SRC_PH2     = 3'd1,
    SRC_PH3     = 3'd2,
    SRC_PH4     = 3'd3,
    SRC_PROD    = 3'd4,
    SRC_PH_PROD = 3'd5,
    SRC_PH_BEND = 3'd6
  } ph_src_t;

  // where a finished product (or sine) goes
  typedef enum logic [2:0] {
    DST_ACC  = 3'd0,
    DST_HACC = 3'd1,
    DST_TREM = 3'd2,
    DST_BEND = 3'd3,
    DST_F    = 3'd4
  } dst_t;

  typedef enum logic [2:0] {
    UI_TERM   = 3'd0,
    UI_AGEMUL = 3'd1,
    UI_FALL   = 3'd2,
    UI_FT     = 3'd3,
    UI_FIN    = 3'd4
  } uop_t;

  typedef struct packed {
    uop_t        op;
    ph_src_t     src;
    dst_t        dst;
    logic [26:0] k;
  } uinst_t;

  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_START    = 4'd1,
    DP_LDPH     = 4'd2,
    DP_MUL_X    = 4'd3,
    DP_MUL_PP   = 4'd4,
    DP_MUL_C    = 4'd5,
    DP_SIN_END  = 4'd6,
    DP_MUL_SK   = 4'd7,
    DP_STORE    = 4'd8,
    DP_MUL_AGE  = 4'd9,
    DP_DEN      = 4'd10,
    DP_DIV_STEP = 4'd11,
    DP_MUL_HF   = 4'd12,
    DP_MUL_FT   = 4'd13,
    DP_FIN      = 4'd14
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    ph_src_t     src;
    dst_t        dst;
    logic [26:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  function automatic uinst_t mk(input uop_t op, input ph_src_t src, input dst_t dst,
                                input int unsigned k);
    uinst_t u;
    u.op  = op;
    u.src = src;
    u.dst = dst;
    u.k   = 27'(k);
    return u;
  endfunction

  // one program per timbre, up to six instructions before the closing UI_FIN
  function automatic uinst_t ucode(input logic bass, input logic [2:0] tone,
                                   input logic [2:0] pc);
    uinst_t fin;
    uinst_t u;
    fin = mk(UI_FIN, SRC_PH, DST_ACC, 0);
    u   = fin;
    unique case ({bass, tone})
      4'b1000: begin
        unique case (pc)
          3'd0:    u = mk(UI_TERM, SRC_PH,  DST_ACC, 107479);
          3'd1:    u = mk(UI_TERM, SRC_PH2, DST_ACC, 17039);
          3'd2:    u = mk(UI_TERM, SRC_PH3, DST_ACC, 6554);
          default: u = fin;
        endcase
      end
      4'b1001: begin
        unique case (pc)
          3'd0:    u = mk(UI_TERM, SRC_PH2, DST_HACC, 23593);
          3'd1:    u = mk(UI_TERM, SRC_PH3, DST_HACC, 11796);
          3'd2:    u = mk(UI_TERM, SRC_PH4, DST_HACC, 6554);
          3'd3:    u = mk(UI_FALL, SRC_PH,  DST_ACC,  3006477);
          3'd4:    u = mk(UI_TERM, SRC_PH,  DST_ACC,  89129);
          default: u = fin;
        endcase
      end
      4'b1010: begin
        unique case (pc)
          3'd0:    u = mk(UI_TERM, SRC_PH,  DST_ACC, 127140);
          3'd1:    u = mk(UI_TERM, SRC_PH2, DST_ACC, 3932);
          default: u = fin;
        endcase
      end
      4'b0000: begin
        unique case (pc)
          3'd0:    u = mk(UI_TERM, SRC_PH2, DST_HACC, 26214);
          3'd1:    u = mk(UI_TERM, SRC_PH3, DST_HACC, 13107);
          3'd2:    u = mk(UI_FALL, SRC_PH,  DST_ACC,  386547);
          3'd3:    u = mk(UI_TERM, SRC_PH,  DST_ACC,  91750);
          default: u = fin;
        endcase
      end
      4'b0001: begin
        unique case (pc)
          3'd0:    u = mk(UI_TERM, SRC_PH2, DST_HACC, 13107);
          3'd1:    u = mk(UI_TERM, SRC_PH3, DST_HACC, 5243);
          3'd2:    u = mk(UI_FALL, SRC_PH,  DST_ACC,  150324);
          3'd3:    u = mk(UI_TERM, SRC_PH,  DST_ACC,  112722);
          default: u = fin;
        endcase
      end
      4'b0010: begin
        unique case (pc)
          3'd0:    u = mk(UI_TERM, SRC_PH2, DST_HACC, 24904);
          3'd1:    u = mk(UI_TERM, SRC_PH3, DST_HACC, 14418);
          3'd2:    u = mk(UI_TERM, SRC_PH4, DST_HACC, 7864);
          3'd3:    u = mk(UI_FALL, SRC_PH,  DST_ACC,  1932735);
          3'd4:    u = mk(UI_TERM, SRC_PH,  DST_ACC,  83886);
          default: u = fin;
        endcase
      end
      4'b0011: begin
        unique case (pc)
          3'd0:    u = mk(UI_AGEMUL, SRC_PH,   DST_ACC,  697932);
          3'd1:    u = mk(UI_TERM,   SRC_PROD, DST_TREM, 15729);
          3'd2:    u = mk(UI_TERM,   SRC_PH,   DST_F,    0);
          3'd3:    u = mk(UI_FT,     SRC_PH,   DST_ACC,  0);
          3'd4:    u = mk(UI_TERM,   SRC_PH4,  DST_HACC, 7864);
          3'd5:    u = mk(UI_FALL,   SRC_PH,   DST_ACC,  515396);
          default: u = fin;
        endcase
      end
      4'b0100: begin
        unique case (pc)
          3'd0:    u = mk(UI_AGEMUL, SRC_PH,      DST_ACC, 56371);
          3'd1:    u = mk(UI_TERM,   SRC_PH_PROD, DST_ACC, 49807);
          3'd2:    u = mk(UI_TERM,   SRC_PH,      DST_ACC, 62915);
          3'd3:    u = mk(UI_TERM,   SRC_PH2,     DST_ACC, 13107);
          default: u = fin;
        endcase
      end
      4'b0101: begin
        unique case (pc)
          3'd0:    u = mk(UI_AGEMUL, SRC_PH,      DST_ACC,  671089);
          3'd1:    u = mk(UI_TERM,   SRC_PROD,    DST_BEND, 90000000);
          3'd2:    u = mk(UI_TERM,   SRC_PH_BEND, DST_ACC,  116654);
          3'd3:    u = mk(UI_TERM,   SRC_PH2,     DST_ACC,  10486);
          3'd4:    u = mk(UI_TERM,   SRC_PH3,     DST_ACC,  3932);
          default: u = fin;
        endcase
      end
      default: u = fin;
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/hvsr_dp.sv
// Renderer datapath: shared multiplier, sine steps, accumulators, falloff divider.
// Driven by hvsr_ctrl commands; depends on hvsr_pkg.
module hvsr_dp #(
  parameter int SAMPLE_BITS = hvsr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic [31:0]         phase,
  input  logic [31:0]         age,
  input  hvsr_pkg::dp_cmd_t   cmd,
  output hvsr_pkg::dp_stat_t  stat,
  output logic signed [15:0]  sample
);
  import hvsr_pkg::*;

  localparam int SH_R = (SAMPLE_BITS < 18) ? 18 - SAMPLE_BITS : 0;
  localparam int SH_L = (SAMPLE_BITS > 18) ? SAMPLE_BITS - 18 : 0;
  localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;
  localparam int CW = $clog2(DIV_STEPS);

  logic [31:0]        ph_r, age_r, sph, bend;
  logic signed [61:0] prod;
  logic signed [18:0] p, trem;
  logic signed [19:0] s, f;
  logic signed [47:0] acc, hacc;
  logic [54:0]        den, rem;
  logic [17:0]        q;
  logic [CW-1:0]      dcnt;
  logic signed [15:0] sample_r;

  logic [31:0]        phsel;
  logic signed [17:0] x;
  logic [17:0]        ax;
  logic [18:0]        one_m;
  logic signed [18:0] pp;
  logic [18:0]        app;
  logic signed [19:0] cc, sv;
  logic signed [30:0] hsh, vsh;
  logic signed [32:0] ma;
  logic signed [28:0] mb;
  logic signed [61:0] mprod, btr;
  logic [55:0]        r2;
  logic signed [47:0] vw, scaled, satv;

  always_comb begin
    case (cmd.src)
      SRC_PH:      phsel = ph_r;
      SRC_PH2:     phsel = ph_r << 1;
      SRC_PH3:     phsel = ph_r + (ph_r << 1);
      SRC_PH4:     phsel = ph_r << 2;
      SRC_PROD:    phsel = prod[31:0];
      SRC_PH_PROD: phsel = ph_r + prod[31:0];
      SRC_PH_BEND: phsel = ph_r + bend;
      default:     phsel = ph_r;
    endcase
  end

  // parabolic sine pieces
  assign x     = sph[31:14];
  assign ax    = x[17] ? 18'(-x) : 18'(x);
  assign one_m = 19'(ONE_Q) - {1'b0, ax};
  assign pp    = prod[33:15];
  assign app   = pp[18] ? 19'(-pp) : 19'(pp);
  assign cc    = prod[36:17] - 20'(p);
  assign sv    = 20'(p) + prod[36:17];
  assign hsh   = hacc[47:17];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      DP_MUL_X:   begin ma = 33'(x);    mb = {10'b0, one_m}; end
      DP_MUL_PP:  begin ma = 33'(pp);   mb = {10'b0, app};   end
      DP_MUL_C:   begin ma = 33'(cc);   mb = 29'(CORR_Q);    end
      DP_MUL_SK:  begin ma = 33'(s);    mb = {2'b0, cmd.k};  end
      DP_MUL_AGE: begin ma = {1'b0, age_r}; mb = {2'b0, cmd.k}; end
      DP_MUL_HF:  begin ma = 33'(hsh);  mb = {11'b0, q};     end
      DP_MUL_FT:  begin ma = 33'(f);    mb = 29'(trem);      end
      default:    begin ma = '0;        mb = '0;             end
    endcase
  end

  assign mprod = ma * mb;
  // vibrato bend truncates toward zero
  assign btr   = prod[61] ? prod + 62'sd131071 : prod;
  assign r2    = {rem, 1'b0};

  assign vsh    = acc[47:17];
  assign vw     = 48'(vsh);
  assign scaled = (vw >>> SH_R) <<< SH_L;
  assign satv   = (scaled > SAT_HI) ? SAT_HI : ((scaled < SAT_LO) ? SAT_LO : scaled);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_START: begin
        ph_r  <= phase;
        age_r <= age;
        acc   <= '0;
        hacc  <= '0;
      end
      DP_LDPH: sph <= phsel;
      DP_MUL_X, DP_MUL_C, DP_MUL_SK, DP_MUL_AGE, DP_MUL_HF, DP_MUL_FT: prod <= mprod;
      DP_MUL_PP: begin
        p    <= pp;
        prod <= mprod;
      end
      DP_SIN_END: begin
        s <= sv;
        if (cmd.dst == DST_F) f <= sv;
      end
      DP_STORE: begin
        case (cmd.dst)
          DST_ACC:  acc  <= acc + prod[47:0];
          DST_HACC: hacc <= hacc + prod[47:0];
          DST_TREM: trem <= 19'(TREM_BASE) + prod[35:17];
          DST_BEND: bend <= btr[48:17];
          default:  ;
        endcase
      end
      DP_DEN: begin
        den  <= 55'(prod[53:0]) + (55'(1) << 32);
        rem  <= 55'(1) << 31;
        q    <= '0;
        dcnt <= '0;
      end
      DP_DIV_STEP: begin
        if (r2 >= {1'b0, den}) begin
          rem <= 55'(r2 - {1'b0, den});
          q   <= {q[16:0], 1'b1};
        end else begin
          rem <= r2[54:0];
          q   <= {q[16:0], 1'b0};
        end
        dcnt <= dcnt + CW'(1);
      end
      DP_FIN: sample_r <= satv[15:0];
      default: ;
    endcase
  end

  // only looked at by the controller while it is stepping the divider
  assign stat.div_done = (dcnt == CW'(DIV_STEPS - 1));
  assign sample        = sample_r;

endmodule

### hw/rtl/hvsr_ctrl.sv
// Renderer controller: handshakes, microcode sequencing, datapath commands.
// Depends on hvsr_pkg.
module hvsr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               is_bass,
  input  logic [2:0]         tone_index,
  output logic               out_valid,
  input  logic               out_stall,
  output hvsr_pkg::dp_cmd_t  cmd,
  input  hvsr_pkg::dp_stat_t stat
);
  import hvsr_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_FETCH = 11'b00000000010,
    ST_X     = 11'b00000000100,
    ST_PP    = 11'b00000001000,
    ST_C     = 11'b00000010000,
    ST_END   = 11'b00000100000,
    ST_MUL   = 11'b00001000000,
    ST_STORE = 11'b00010000000,
    ST_DEN   = 11'b00100000000,
    ST_DIV   = 11'b01000000000,
    ST_HF    = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] pc, pc_next;
  logic       bass_r;
  logic [2:0] tone_r;
  logic       out_valid_next;
  uinst_t     u;

  always_comb begin
    u              = ucode(bass_r, tone_r, pc);
    state_next     = state;
    pc_next        = pc;
    out_valid_next = out_valid && out_stall;
    cmd.op         = DP_NOP;
    cmd.src        = u.src;
    cmd.dst        = u.dst;
    cmd.k          = u.k;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_START;
          pc_next    = '0;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        unique case (u.op)
          UI_TERM: begin
            cmd.op     = DP_LDPH;
            state_next = ST_X;
          end
          UI_AGEMUL: begin
            cmd.op  = DP_MUL_AGE;
            pc_next = pc + 3'd1;
          end
          UI_FALL: begin
            cmd.op     = DP_MUL_AGE;
            state_next = ST_DEN;
          end
          UI_FT: begin
            cmd.op     = DP_MUL_FT;
            state_next = ST_STORE;
          end
          UI_FIN: begin
            // result register frees up in the same cycle it is taken
            if (!out_valid || !out_stall) begin
              cmd.op         = DP_FIN;
              out_valid_next = 1'b1;
              state_next     = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_X: begin
        cmd.op     = DP_MUL_X;
        state_next = ST_PP;
      end
      ST_PP: begin
        cmd.op     = DP_MUL_PP;
        state_next = ST_C;
      end
      ST_C: begin
        cmd.op     = DP_MUL_C;
        state_next = ST_END;
      end
      ST_END: begin
        cmd.op = DP_SIN_END;
        if (u.dst == DST_F) begin
          pc_next    = pc + 3'd1;
          state_next = ST_FETCH;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.op     = DP_MUL_SK;
        state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.op     = DP_STORE;
        pc_next    = pc + 3'd1;
        state_next = ST_FETCH;
      end
      ST_DEN: begin
        cmd.op     = DP_DEN;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_done) state_next = ST_HF;
      end
      ST_HF: begin
        cmd.op     = DP_MUL_HF;
        state_next = ST_STORE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      bass_r <= is_bass;
      tone_r <= tone_index;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

### hw/rtl/harmonic_voice_sample_renderer_top.sv
// channel | signals                               | direction
// input   | in_valid, in_stall, is_bass, tone_index, phase, age | in (stall out)
// output  | out_valid, out_stall, sample           | out (stall in)
//
// Per item the sequencer runs its timbre's microcode: each harmonic term loads a phase,
// steps the sine, then scales and stores it; a falloff term adds an age product and the
// divider. Work is serialised on the one shared 33x29 multiplier and the 18-step divider.
// One item at a time; a result waits in its register while the next item is taken.
// rst is synchronous, active high; clears the sequencer and out_valid.
module harmonic_voice_sample_renderer_top #(
  parameter int SAMPLE_BITS = hvsr_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               is_bass,
  input  logic [2:0]         tone_index,
  input  logic [31:0]        phase,
  input  logic [31:0]        age,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample
);
  import hvsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hvsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .is_bass    (is_bass),
    .tone_index (tone_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  hvsr_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .phase  (phase),
    .age    (age),
    .cmd    (cmd),
    .stat   (stat),
    .sample (sample)
  );

endmodule

### hw/rtl/hvsr_chk.sv
// Port-level checks for the renderer top, and the bind that attaches them.
// No package dependency.
module hvsr_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(sample))
    else $error("sample changed while stalled");

  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

endmodule

bind harmonic_voice_sample_renderer_top hvsr_chk u_chk (.*);
